// ===== hw/rtl/gbn_pkg.sv =====
`timescale 1ns / 1ps

package gbn_pkg;

    // Field widths of the channels
    localparam int CMD_W       = 2;
    localparam int PAY_FIELD_W = 64;
    localparam int SEQ_FIELD_W = 16;
    localparam int EV_W        = 3;
    localparam int TM_W        = 2;
    localparam int WIN_REG_W   = 4;

    localparam logic [WIN_REG_W-1:0] WIN_RESET = 4'd8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

    // Event codes
    localparam logic [EV_W-1:0] EV_TX      = 3'd0;
    localparam logic [EV_W-1:0] EV_REFUSED = 3'd1;
    localparam logic [EV_W-1:0] EV_ACK_OK  = 3'd2;
    localparam logic [EV_W-1:0] EV_ACK_BAD = 3'd3;
    localparam logic [EV_W-1:0] EV_IDLE    = 3'd4;

    // Timer actions
    localparam logic [TM_W-1:0] TM_NONE    = 2'd0;
    localparam logic [TM_W-1:0] TM_START   = 2'd1;
    localparam logic [TM_W-1:0] TM_STOP    = 2'd2;
    localparam logic [TM_W-1:0] TM_RESTART = 2'd3;

    typedef struct packed {
        logic [EV_W-1:0]        event_res;
        logic [SEQ_FIELD_W-1:0] packet_seq;
        logic [PAY_FIELD_W-1:0] packet_payload;
        logic [TM_W-1:0]        timer_action;
        logic [SEQ_FIELD_W-1:0] timer_seq;
        logic                   window_full;
        logic                   last_of_burst;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic latch_in;
        logic run_single;
        logic burst_start;
        logic burst_emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             cnt_zero;
        logic             burst_last;
        logic             out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/gbn_in_if.sv =====
`timescale 1ns / 1ps

interface gbn_in_if;
    logic                               valid;
    logic                               ready;
    logic [gbn_pkg::CMD_W-1:0]          command;
    logic [gbn_pkg::PAY_FIELD_W-1:0]    message_payload;
    logic [gbn_pkg::SEQ_FIELD_W-1:0]    ack_number;
    logic                               ack_checksum_ok;

    modport source (output valid, command, message_payload, ack_number, ack_checksum_ok,
                    input ready);
    modport sink (input valid, command, message_payload, ack_number, ack_checksum_ok,
                  output ready);
endinterface

// ===== hw/rtl/gbn_out_if.sv =====
`timescale 1ns / 1ps

interface gbn_out_if;
    logic                               valid;
    logic                               ready;
    logic [gbn_pkg::EV_W-1:0]           event_res;
    logic [gbn_pkg::SEQ_FIELD_W-1:0]    packet_seq;
    logic [gbn_pkg::PAY_FIELD_W-1:0]    packet_payload;
    logic [gbn_pkg::TM_W-1:0]           timer_action;
    logic [gbn_pkg::SEQ_FIELD_W-1:0]    timer_seq;
    logic                               window_full;
    logic                               last_of_burst;

    modport source (output valid, event_res, packet_seq, packet_payload, timer_action,
                    timer_seq, window_full, last_of_burst, input ready);
    modport sink (input valid, event_res, packet_seq, packet_payload, timer_action,
                  timer_seq, window_full, last_of_burst, output ready);
endinterface

// ===== hw/rtl/gbn_cfg_if.sv =====
`timescale 1ns / 1ps

interface gbn_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gbn_pkg::WIN_REG_W-1:0]      data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/gbn_ram.sv =====
`timescale 1ns / 1ps

module gbn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/gbn_ctrl.sv =====
`timescale 1ns / 1ps

module gbn_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gbn_pkg::t_dp_status i_st,
    output gbn_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_BURST = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_st.op == gbn_pkg::CMD_TIMEOUT && !i_st.cnt_zero) begin
                    // prime the first read of the burst
                    o_cmd.burst_start = 1'b1;
                    n_state           = S_BURST;
                end else if (i_st.op == gbn_pkg::CMD_SEND || i_st.op == gbn_pkg::CMD_ACK ||
                             i_st.op == gbn_pkg::CMD_TIMEOUT) begin
                    if (i_st.out_free) begin
                        o_cmd.run_single = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else begin
                    // drop unknown command
                    n_state = S_IDLE;
                end
            end
            S_BURST: begin
                if (i_st.out_free) begin
                    o_cmd.burst_emit = 1'b1;
                    if (i_st.burst_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== hw/rtl/gbn_dp.sv =====
`timescale 1ns / 1ps

module gbn_dp #(
    parameter int DEPTH        = 8,
    parameter int SEQ_BITS     = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gbn_pkg::WIN_REG_W-1:0]       i_cfg_data,
    input  logic [gbn_pkg::CMD_W-1:0]           i_command,
    input  logic [gbn_pkg::PAY_FIELD_W-1:0]     i_message_payload,
    input  logic [gbn_pkg::SEQ_FIELD_W-1:0]     i_ack_number,
    input  logic                                i_ack_checksum_ok,
    input  gbn_pkg::t_dp_cmd                    i_cmd,
    output gbn_pkg::t_dp_status                 o_st,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output gbn_pkg::t_result                    o_out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WRW   = gbn_pkg::WIN_REG_W;
    localparam int SFW   = gbn_pkg::SEQ_FIELD_W;
    localparam int PFW   = gbn_pkg::PAY_FIELD_W;

    localparam logic [WRW-1:0]   DEPTH_REG = WRW'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    logic [WRW-1:0]                 r_window;
    logic [SEQ_BITS-1:0]            r_base;
    logic [SEQ_BITS-1:0]            r_next;
    logic [CNT_W-1:0]               r_count;
    logic [PTR_W-1:0]               r_base_ptr;
    logic [PTR_W-1:0]               r_tail_ptr;
    logic [PTR_W-1:0]               r_burst_ptr;
    logic [CNT_W-1:0]               r_idx;
    logic [gbn_pkg::CMD_W-1:0]      r_op;
    logic [PAYLOAD_BITS-1:0]        r_pay;
    logic [SEQ_BITS-1:0]            r_ack;
    logic                           r_ok;
    logic                           r_out_valid;
    gbn_pkg::t_result               r_out;

    logic [SEQ_BITS-1:0]            n_base;
    logic [SEQ_BITS-1:0]            n_next;
    logic [CNT_W-1:0]               n_count;
    logic [PTR_W-1:0]               n_base_ptr;
    logic [PTR_W-1:0]               n_tail_ptr;
    gbn_pkg::t_result               n_res;

    logic [WRW-1:0]                 win_clip;
    logic [CNT_W-1:0]               eff_win;
    logic [SEQ_BITS-1:0]            ack_dist;
    logic                           ack_take;
    logic [CNT_W-1:0]               ack_num;
    logic [CNT_W:0]                 ptr_sum;
    logic [SEQ_BITS-1:0]            ack_next;
    logic                           ram_we;
    logic                           ram_re;
    logic [PTR_W-1:0]               ram_raddr;
    logic [PAYLOAD_BITS-1:0]        ram_rdata;
    logic                           out_free;
    logic                           burst_last;

    gbn_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail_ptr),
        .i_wdata (r_pay),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        win_clip = r_window;
        if (r_window == '0) begin
            win_clip = WRW'(1);
        end else if (r_window > DEPTH_REG) begin
            win_clip = DEPTH_REG;
        end
        eff_win = CNT_W'(win_clip);
    end

    assign ack_dist = r_ack - r_base;
    assign ack_take = r_ok && (ack_dist < SEQ_BITS'(r_count));
    assign ack_num  = CNT_W'(ack_dist) + CNT_W'(1);
    assign ack_next = r_ack + SEQ_BITS'(1);

    always_comb begin
        ptr_sum = (CNT_W + 1)'(r_base_ptr) + (CNT_W + 1)'(ack_num);
        if (ptr_sum >= (CNT_W + 1)'(DEPTH)) begin
            ptr_sum = ptr_sum - (CNT_W + 1)'(DEPTH);
        end
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign burst_last = (r_idx + CNT_W'(1)) == r_count;

    // single-result commands
    always_comb begin
        n_base     = r_base;
        n_next     = r_next;
        n_count    = r_count;
        n_base_ptr = r_base_ptr;
        n_tail_ptr = r_tail_ptr;
        ram_we     = 1'b0;
        n_res      = '0;
        n_res.last_of_burst = 1'b1;
        unique case (r_op)
            gbn_pkg::CMD_SEND: begin
                if (r_count < eff_win) begin
                    ram_we             = i_cmd.run_single;
                    n_count            = r_count + CNT_W'(1);
                    n_next             = r_next + SEQ_BITS'(1);
                    n_tail_ptr         = ptr_inc(r_tail_ptr);
                    n_res.event_res    = gbn_pkg::EV_TX;
                    n_res.packet_seq   = SFW'(r_next);
                    n_res.packet_payload = PFW'(r_pay);
                    if (r_count == '0) begin
                        n_res.timer_action = gbn_pkg::TM_START;
                        n_res.timer_seq    = SFW'(r_next);
                    end
                end else begin
                    n_res.event_res = gbn_pkg::EV_REFUSED;
                end
            end
            gbn_pkg::CMD_ACK: begin
                if (r_count == '0) begin
                    n_res.event_res = gbn_pkg::EV_IDLE;
                end else if (ack_take) begin
                    n_count         = r_count - ack_num;
                    n_base          = ack_next;
                    n_base_ptr      = PTR_W'(ptr_sum);
                    n_res.event_res = gbn_pkg::EV_ACK_OK;
                    if (r_count == ack_num) begin
                        n_res.timer_action = gbn_pkg::TM_STOP;
                        n_res.timer_seq    = SFW'(r_base);
                    end else begin
                        n_res.timer_action = gbn_pkg::TM_RESTART;
                        n_res.timer_seq    = SFW'(ack_next);
                    end
                end else begin
                    n_res.event_res = gbn_pkg::EV_ACK_BAD;
                end
            end
            gbn_pkg::CMD_TIMEOUT: begin
                n_res.event_res = gbn_pkg::EV_IDLE;
            end
            default: begin
                n_res.event_res = gbn_pkg::EV_IDLE;
            end
        endcase
        n_res.window_full = (n_count >= eff_win);
    end

    // burst reads walk the ring one entry per emitted word
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_burst_ptr;
        if (i_cmd.burst_start) begin
            ram_re    = 1'b1;
            ram_raddr = r_base_ptr;
        end else if (i_cmd.burst_emit && !burst_last) begin
            ram_re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= gbn_pkg::WIN_RESET;
            r_base      <= SEQ_BITS'(1);
            r_next      <= SEQ_BITS'(1);
            r_count     <= '0;
            r_base_ptr  <= '0;
            r_tail_ptr  <= '0;
            r_burst_ptr <= '0;
            r_idx       <= '0;
            r_op        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
            if (i_cmd.latch_in) begin
                r_op <= i_command;
            end
            if (i_cmd.run_single) begin
                r_base     <= n_base;
                r_next     <= n_next;
                r_count    <= n_count;
                r_base_ptr <= n_base_ptr;
                r_tail_ptr <= n_tail_ptr;
            end
            if (i_cmd.burst_start) begin
                r_burst_ptr <= ptr_inc(r_base_ptr);
                r_idx       <= '0;
            end else if (i_cmd.burst_emit) begin
                r_burst_ptr <= ptr_inc(r_burst_ptr);
                r_idx       <= r_idx + CNT_W'(1);
            end
            if (i_cmd.run_single || i_cmd.burst_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_pay <= PAYLOAD_BITS'(i_message_payload);
            r_ack <= SEQ_BITS'(i_ack_number);
            r_ok  <= i_ack_checksum_ok;
        end
        if (i_cmd.run_single) begin
            r_out <= n_res;
        end else if (i_cmd.burst_emit) begin
            r_out.event_res      <= gbn_pkg::EV_TX;
            r_out.packet_seq     <= SFW'(r_base + SEQ_BITS'(r_idx));
            r_out.packet_payload <= PFW'(ram_rdata);
            r_out.timer_action   <= (r_idx == '0) ? gbn_pkg::TM_RESTART : gbn_pkg::TM_NONE;
            r_out.timer_seq      <= (r_idx == '0) ? SFW'(r_base) : '0;
            r_out.window_full    <= (r_count >= eff_win);
            r_out.last_of_burst  <= burst_last;
        end
    end

    assign o_st.op         = r_op;
    assign o_st.cnt_zero   = (r_count == '0);
    assign o_st.burst_last = burst_last;
    assign o_st.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hw/rtl/go_back_n_sender_window_unit.sv =====
`timescale 1ns / 1ps
// Go-back-N sender window.
// Channels: i_in carries one command word (send, ack, timeout) with its
// payload, ack number and checksum flag; o_out delivers result words; i_cfg
// writes the window_in_use register and is always ready. All use valid/ready.
// Sequence: a word accepted in idle moves the controller to execute, where its
// result is registered in the output register once that register is free.
// Send and ack words follow this accept-then-execute sequence of the
// controller, and no new word is accepted until the last one has executed.
// A timeout with packets outstanding first primes the payload-ring read,
// then the ring's registered read port yields one retransmitted word per
// cycle while the output is not stalled.
// The output register holds a finished word, so the next command word is
// accepted while that word waits to be taken.
// Stall: while a word waits with o_out.ready low, execution and the burst
// walk hold and the word stays put; input stalls until the controller is idle.
// Reset (i_rst_n low, synchronous): window base and next sequence go to 1,
// nothing is outstanding, window_in_use returns to 8, o_out drops valid.
// The payload ring needs no clearing; entries are written before being read.
// Unknown command code 3 is consumed with no result.

module go_back_n_sender_window_unit #(
    parameter int WINDOW       = 8,
    parameter int SEQ_BITS     = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gbn_in_if.sink     i_in,
    gbn_out_if.source  o_out,
    gbn_cfg_if.sink    i_cfg
);

    // ring holds at most eight packets
    localparam int DEPTH = (WINDOW < 8) ? WINDOW : 8;

    gbn_pkg::t_dp_cmd    dp_cmd;
    gbn_pkg::t_dp_status dp_st;
    gbn_pkg::t_result    res;
    logic                in_ready;
    logic                out_valid;

    // Sequence the command: accept, execute, walk the burst
    gbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_st       (dp_st),
        .o_cmd      (dp_cmd)
    );

    // Window state, payload ring and output register
    gbn_dp #(
        .DEPTH        (DEPTH),
        .SEQ_BITS     (SEQ_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_data        (i_cfg.data),
        .i_command         (i_in.command),
        .i_message_payload (i_in.message_payload),
        .i_ack_number      (i_in.ack_number),
        .i_ack_checksum_ok (i_in.ack_checksum_ok),
        .i_cmd             (dp_cmd),
        .o_st              (dp_st),
        .o_out_valid       (out_valid),
        .i_out_ready       (o_out.ready),
        .o_out             (res)
    );

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid          = out_valid;
    assign o_out.event_res      = res.event_res;
    assign o_out.packet_seq     = res.packet_seq;
    assign o_out.packet_payload = res.packet_payload;
    assign o_out.timer_action   = res.timer_action;
    assign o_out.timer_seq      = res.timer_seq;
    assign o_out.window_full    = res.window_full;
    assign o_out.last_of_burst  = res.last_of_burst;

    // One command word at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted twice in a row");

    // Only retransmit bursts span several words
    a_non_tx_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.event_res != gbn_pkg::EV_TX) |-> o_out.last_of_burst)
        else $error("non-transmit result not marked last");

    // Timer start ties to the packet just sent
    a_start_on_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.timer_action == gbn_pkg::TM_START) |->
        (o_out.event_res == gbn_pkg::EV_TX && o_out.timer_seq == o_out.packet_seq))
        else $error("timer start not tied to transmitted packet");

endmodule

// ===== tb/tb_go_back_n_sender_window_unit.sv =====
`timescale 1ns / 1ps

module tb_go_back_n_sender_window_unit;

    localparam logic [gbn_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RING_DEPTH  = 8;
    localparam int SETTLE      = 6;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int NUM_PHASES  = 6;

    // How an ack number is chosen when the word goes out on the bus
    typedef enum logic [2:0] {
        PICK_LITERAL,
        PICK_IN_WINDOW,
        PICK_NEWEST,
        PICK_BELOW_BASE,
        PICK_PAST_NEWEST
    } t_ack_pick;

    typedef struct {
        logic [gbn_pkg::CMD_W-1:0]       command;
        logic [gbn_pkg::PAY_FIELD_W-1:0] payload;
        logic [gbn_pkg::SEQ_FIELD_W-1:0] ack;
        logic                            ok;
        t_ack_pick                       pick;
        bit                              drain_first;
    } t_cmd_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gbn_in_if  in_if ();
    gbn_out_if out_if ();
    gbn_cfg_if cfg_if ();

    go_back_n_sender_window_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the sender window
    logic [gbn_pkg::WIN_REG_W-1:0]   win_reg = gbn_pkg::WIN_RESET;
    logic [gbn_pkg::PAY_FIELD_W-1:0] ring [RING_DEPTH];
    logic [gbn_pkg::SEQ_FIELD_W-1:0] base = 16'd1;
    logic [gbn_pkg::SEQ_FIELD_W-1:0] next_seq = 16'd1;
    logic [3:0]                      in_flight = 4'd0;
    logic                            full = 1'b0;

    t_cmd_word        pending_cmds [$];
    gbn_pkg::t_result expected_words [$];

    int  src_idle_pct = 0;
    int  snk_stall_pct = 0;
    int  mismatches = 0;
    int  cycles = 0;
    logic in_fire = 1'b0;

    task automatic push_result(input logic [gbn_pkg::EV_W-1:0] ev,
                               input logic [gbn_pkg::SEQ_FIELD_W-1:0] seq,
                               input logic [gbn_pkg::PAY_FIELD_W-1:0] pay,
                               input logic [gbn_pkg::TM_W-1:0] tm,
                               input logic [gbn_pkg::SEQ_FIELD_W-1:0] tseq, input logic last);
        gbn_pkg::t_result r;
        r.event_res      = ev;
        r.packet_seq     = seq;
        r.packet_payload = pay;
        r.timer_action   = tm;
        r.timer_seq      = tseq;
        r.window_full    = full;
        r.last_of_burst  = last;
        expected_words.push_back(r);
    endtask

    // Apply one accepted command word to the shadow window and queue its results
    task automatic advance_window(input logic [gbn_pkg::CMD_W-1:0] cmd,
                                  input logic [gbn_pkg::PAY_FIELD_W-1:0] pay,
                                  input logic [gbn_pkg::SEQ_FIELD_W-1:0] ack, input logic ok);
        logic [3:0]                      eff;
        logic [gbn_pkg::SEQ_FIELD_W-1:0] ack_gap;
        logic [gbn_pkg::SEQ_FIELD_W-1:0] old_base;
        logic [gbn_pkg::SEQ_FIELD_W-1:0] seq;
        logic [3:0]                      num;
        logic                            was_empty;
        eff = (win_reg == 0) ? 4'd1 : (win_reg > RING_DEPTH) ? 4'(RING_DEPTH) : win_reg;
        case (cmd)
            gbn_pkg::CMD_SEND: begin
                if (in_flight < eff) begin
                    seq = next_seq;
                    was_empty = (in_flight == 0);
                    ring[in_flight[2:0]] = pay;
                    in_flight = in_flight + 4'd1;
                    next_seq = next_seq + 16'd1;
                    full = (in_flight >= eff);
                    push_result(gbn_pkg::EV_TX, seq, pay,
                                was_empty ? gbn_pkg::TM_START : gbn_pkg::TM_NONE,
                                was_empty ? seq : '0, 1'b1);
                end else begin
                    full = 1'b1;
                    push_result(gbn_pkg::EV_REFUSED, '0, '0, gbn_pkg::TM_NONE, '0, 1'b1);
                end
            end
            gbn_pkg::CMD_ACK: begin
                ack_gap = ack - base;
                if (in_flight == 0) begin
                    full = (in_flight >= eff);
                    push_result(gbn_pkg::EV_IDLE, '0, '0, gbn_pkg::TM_NONE, '0, 1'b1);
                end else if (ok && ack_gap < in_flight) begin
                    // Cumulative ack: slide the ring down past everything acknowledged
                    num = 4'(ack_gap) + 4'd1;
                    old_base = base;
                    for (int i = 0; i < RING_DEPTH; i++) begin
                        if (i + num < in_flight) ring[i] = ring[i + num];
                    end
                    in_flight = in_flight - num;
                    base = ack + 16'd1;
                    full = (in_flight >= eff);
                    if (in_flight == 0)
                        push_result(gbn_pkg::EV_ACK_OK, '0, '0, gbn_pkg::TM_STOP, old_base, 1'b1);
                    else
                        push_result(gbn_pkg::EV_ACK_OK, '0, '0, gbn_pkg::TM_RESTART, base, 1'b1);
                end else begin
                    full = (in_flight >= eff);
                    push_result(gbn_pkg::EV_ACK_BAD, '0, '0, gbn_pkg::TM_NONE, '0, 1'b1);
                end
            end
            gbn_pkg::CMD_TIMEOUT: begin
                full = (in_flight >= eff);
                if (in_flight == 0) begin
                    push_result(gbn_pkg::EV_IDLE, '0, '0, gbn_pkg::TM_NONE, '0, 1'b1);
                end else begin
                    // Go back N: resend everything outstanding, oldest first
                    for (int i = 0; i < in_flight; i++) begin
                        push_result(gbn_pkg::EV_TX, base + 16'(i), ring[i],
                                    (i == 0) ? gbn_pkg::TM_RESTART : gbn_pkg::TM_NONE,
                                    (i == 0) ? base : '0, (i + 1 == in_flight));
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Sample both channels at the rising edge: predict on input, compare on output
    always @(posedge i_clk) begin
        gbn_pkg::t_result want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else if (i_rst_n) begin
            in_fire <= in_if.valid && in_if.ready;
            if (in_if.valid && in_if.ready)
                advance_window(in_if.command, in_if.message_payload, in_if.ack_number,
                               in_if.ack_checksum_ok);
            if (out_if.valid && out_if.ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected: event %0d", out_if.event_res);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("event_res", want.event_res, out_if.event_res);
                    check_field("packet_seq", want.packet_seq, out_if.packet_seq);
                    check_field("packet_payload", want.packet_payload, out_if.packet_payload);
                    check_field("timer_action", want.timer_action, out_if.timer_action);
                    check_field("timer_seq", want.timer_seq, out_if.timer_seq);
                    check_field("window_full", want.window_full, out_if.window_full);
                    check_field("last_of_burst", want.last_of_burst, out_if.last_of_burst);
                end
            end
        end
    end

    // Command driver: present the next word once the current one is taken
    always @(negedge i_clk) begin
        t_cmd_word w;
        if (!in_if.valid || in_fire) begin
            if (pending_cmds.size() != 0 && i_rst_n
                    && (!pending_cmds[0].drain_first || expected_words.size() == 0)
                    && $urandom_range(99) >= src_idle_pct) begin
                w = pending_cmds.pop_front();
                // Resolve relative ack numbers against the window as it stands now
                case (w.pick)
                    PICK_IN_WINDOW:
                        if (in_flight != 0) w.ack = base + 16'($urandom_range(in_flight - 1));
                    PICK_NEWEST:      w.ack = next_seq - 16'd1;
                    PICK_BELOW_BASE:  w.ack = base - 16'd1;
                    PICK_PAST_NEWEST: w.ack = next_seq;
                    default: ;
                endcase
                in_if.valid           <= 1'b1;
                in_if.command         <= w.command;
                in_if.message_payload <= w.payload;
                in_if.ack_number      <= w.ack;
                in_if.ack_checksum_ok <= w.ok;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    function automatic t_cmd_word cmd_word(input logic [gbn_pkg::CMD_W-1:0] cmd,
                                           input logic [gbn_pkg::PAY_FIELD_W-1:0] pay,
                                           input logic [gbn_pkg::SEQ_FIELD_W-1:0] ack,
                                           input logic ok, input t_ack_pick pick);
        t_cmd_word w;
        w.command     = cmd;
        w.payload     = pay;
        w.ack         = ack;
        w.ok          = ok;
        w.pick        = pick;
        w.drain_first = 1'b0;
        return w;
    endfunction

    // Mostly well-formed traffic: sends, in-window acks and timeouts, with some noise
    function automatic t_cmd_word random_word();
        int r;
        logic [gbn_pkg::PAY_FIELD_W-1:0] pay;
        logic [gbn_pkg::SEQ_FIELD_W-1:0] ack;
        r = $urandom_range(99);
        pay = {$urandom, $urandom};
        ack = 16'($urandom);
        if ($urandom_range(9) == 0) pay = $urandom_range(1) ? '1 : '0;
        if (r < 45) return cmd_word(gbn_pkg::CMD_SEND, pay, ack, 1'($urandom), PICK_LITERAL);
        if (r < 75) return cmd_word(gbn_pkg::CMD_ACK, pay, ack, 1'b1, PICK_IN_WINDOW);
        if (r < 79) return cmd_word(gbn_pkg::CMD_ACK, pay, ack, 1'b1, PICK_NEWEST);
        if (r < 82) return cmd_word(gbn_pkg::CMD_ACK, pay, ack, 1'b1, PICK_BELOW_BASE);
        if (r < 84) return cmd_word(gbn_pkg::CMD_ACK, pay, ack, 1'b1, PICK_PAST_NEWEST);
        if (r < 87) return cmd_word(gbn_pkg::CMD_ACK, pay, ack, 1'($urandom), PICK_LITERAL);
        if (r < 89) return cmd_word(gbn_pkg::CMD_ACK, pay, ack, 1'b0, PICK_IN_WINDOW);
        if (r < 97) return cmd_word(gbn_pkg::CMD_TIMEOUT, pay, ack, 1'($urandom), PICK_LITERAL);
        return cmd_word(CMD_UNUSED, pay, ack, 1'($urandom), PICK_LITERAL);
    endfunction

    // Hold until every word is taken and every result is back, then let the pipe settle
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (pending_cmds.size() != 0 || in_if.valid || expected_words.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [gbn_pkg::WIN_REG_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk);
        while (!(cfg_if.valid && cfg_if.ready));
        win_reg = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    int unsigned ph_win   [NUM_PHASES] = '{1, 0, 3, 8, 15, 8};
    int unsigned ph_idle  [NUM_PHASES] = '{0, 86, 0, 20, 0, 0};
    int unsigned ph_stall [NUM_PHASES] = '{0, 0, 86, 20, 0, 86};
    int unsigned ph_items [NUM_PHASES] = '{55, 45, 85, 85, 85, 80};

    initial begin
        t_cmd_word w;
        i_rst_n               = 1'b0;
        in_if.valid           = 1'b0;
        in_if.command         = gbn_pkg::CMD_SEND;
        in_if.message_payload = '0;
        in_if.ack_number      = '0;
        in_if.ack_checksum_ok = 1'b0;
        out_if.ready          = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.data           = gbn_pkg::WIN_RESET;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty window, out-of-window and corrupt acks, partial and full
        // acks, fill to full, refused send, full burst, unknown command
        pending_cmds.push_back(cmd_word(gbn_pkg::CMD_ACK, '0, 16'h0000, 1'b1, PICK_LITERAL));
        pending_cmds.push_back(cmd_word(gbn_pkg::CMD_TIMEOUT, '0, '0, 1'b0, PICK_LITERAL));
        pending_cmds.push_back(cmd_word(gbn_pkg::CMD_SEND, '1, '0, 1'b0, PICK_LITERAL));
        pending_cmds.push_back(cmd_word(gbn_pkg::CMD_SEND, '0, '1, 1'b1, PICK_LITERAL));
        pending_cmds.push_back(cmd_word(gbn_pkg::CMD_ACK, '0, 16'h0000, 1'b1, PICK_LITERAL));
        pending_cmds.push_back(cmd_word(gbn_pkg::CMD_ACK, '0, 16'h0001, 1'b0, PICK_LITERAL));
        pending_cmds.push_back(cmd_word(gbn_pkg::CMD_ACK, '0, 16'hFFFF, 1'b1, PICK_LITERAL));
        pending_cmds.push_back(cmd_word(gbn_pkg::CMD_TIMEOUT, '0, '0, 1'b0, PICK_LITERAL));
        pending_cmds.push_back(cmd_word(gbn_pkg::CMD_ACK, '0, 16'h0001, 1'b1, PICK_LITERAL));
        pending_cmds.push_back(cmd_word(gbn_pkg::CMD_ACK, '0, 16'h0002, 1'b1, PICK_LITERAL));
        pending_cmds.push_back(cmd_word(CMD_UNUSED, '1, '1, 1'b1, PICK_LITERAL));
        for (int i = 0; i < 8; i++)
            pending_cmds.push_back(cmd_word(gbn_pkg::CMD_SEND, {$urandom, $urandom}, '0, 1'b0,
                                            PICK_LITERAL));
        pending_cmds.push_back(cmd_word(gbn_pkg::CMD_SEND, '1, '0, 1'b0, PICK_LITERAL));
        pending_cmds.push_back(cmd_word(gbn_pkg::CMD_TIMEOUT, '0, '0, 1'b0, PICK_LITERAL));
        pending_cmds.push_back(cmd_word(gbn_pkg::CMD_ACK, '0, '0, 1'b1, PICK_PAST_NEWEST));
        pending_cmds.push_back(cmd_word(gbn_pkg::CMD_ACK, '0, '0, 1'b1, PICK_NEWEST));
        wait_quiet();

        // Random phases, each with its own window and idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            src_idle_pct  = 0;
            snk_stall_pct = 0;
            write_window(gbn_pkg::WIN_REG_W'(ph_win[p]));
            src_idle_pct  = ph_idle[p];
            snk_stall_pct = ph_stall[p];
            for (int i = 0; i < ph_items[p]; i++) begin
                w = random_word();
                // Drain completely before the first word of every phase and, at random, before some others
                w.drain_first = (i == 0) || ($urandom_range(49) == 0);
                pending_cmds.push_back(w);
            end
            wait_quiet();
        end

        if (expected_words.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
